// ===== sv/lsts_pkg.sv =====
// lsts_pkg: shared widths and the hash map entry layout for the
// longest target-sum run block; no dependencies
package lsts_pkg;

    // running sum and target width
    localparam int SUM_W = 32;
    // run length and element count width
    localparam int LEN_W = 17;
    // stored first index width
    localparam int IDX_W = 16;
    // sequence tag width kept in each map entry
    localparam int EPOCH_W = 8;

    // one map entry: prefix sum, first index where it occurred, sequence tag
    typedef struct packed {
        logic [SUM_W-1:0]   key;
        logic [IDX_W-1:0]   first;
        logic [EPOCH_W-1:0] epoch;
    } map_entry_t;

endpackage

// ===== sv/lsts_map_ram.sv =====
// lsts_map_ram: single-port-write, single-port-read synchronous memory
// holding the prefix sum map; depends on lsts_pkg for the entry type
module lsts_map_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  lsts_pkg::map_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output lsts_pkg::map_entry_t rd_data
);

    lsts_pkg::map_entry_t mem_array [DEPTH];
    lsts_pkg::map_entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/longest_subarray_target_sum_unit.sv =====
// longest_subarray_target_sum_unit: top level, sequencer around an
// open-addressed prefix sum map; depends on lsts_pkg and lsts_map_ram
//
// Usage: elements arrive on the input channel (element_value, last_element,
// in_valid, in_stall); one item is taken when in_valid is high and in_stall
// is low. Each element is added to a 32-bit running sum; the sum minus the
// target is looked up in a hashed map of first indexes, then the sum itself
// is looked up and inserted if new. The item with last_element set produces
// one result item (best_length, map_overflow, sequence_too_long) on the
// output channel, held in an output register until out_stall is low.
// Per element: DIFF, HASH, RD, CMP for the difference lookup, then HASH, RD,
// CMP for the sum lookup; each extra linear probe repeats RD and CMP (the
// map's one read port serializes probes), with in_stall high throughout. An
// element beyond the maximum length is only flagged. The last element then
// passes FIN to emit, holding there while the previous result waits behind
// out_stall. Reset: a clearing pass writes every map entry with an invalid
// tag; in_stall stays high meanwhile. The pass repeats after every 255
// sequences when the tag counter wraps. The user must write target_sum
// through cfg_wr_en / cfg_wr_data while idle; the block does not enforce it.
module longest_subarray_target_sum_unit #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int MAX_LENGTH    = 65536,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic signed [lsts_pkg::SUM_W-1:0]   cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ELEMENT_WIDTH-1:0]     element_value,
    input  logic                                last_element,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lsts_pkg::LEN_W-1:0]          best_length,
    output logic                                map_overflow,
    output logic                                sequence_too_long
);

    localparam int SUM_W   = lsts_pkg::SUM_W;
    localparam int LEN_W   = lsts_pkg::LEN_W;
    localparam int IDX_W   = lsts_pkg::IDX_W;
    localparam int EPOCH_W = lsts_pkg::EPOCH_W;
    localparam int AW      = $clog2(TABLE_DEPTH);

    localparam logic [AW:0]        DEPTH_V   = (AW + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [LEN_W-1:0]   MAX_LEN_V = LEN_W'(MAX_LENGTH);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_HASH = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // lookup passes
    localparam logic PASS_DIFF = 1'b0;
    localparam logic PASS_SUM  = 1'b1;

    // fold a 32-bit key into a table index below TABLE_DEPTH
    function automatic logic [AW-1:0] hash_index(input logic [SUM_W-1:0] key);
        logic [AW-1:0] h;
        h = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            h[i % AW] = h[i % AW] ^ key[i];
        end
        if ({1'b0, h} >= DEPTH_V)
        begin
            h = AW'({1'b0, h} - DEPTH_V);
        end
        return h;
    endfunction

    // next clearing address
    function automatic logic [AW-1:0] probe_addr_inc_clr(input logic [AW-1:0] addr);
        return (addr == LAST_ADDR) ? '0 : addr + AW'(1);
    endfunction

    // control registers
    logic [2:0]         state_reg, state_next;
    logic [SUM_W-1:0]   target_reg, target_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]   best_reg, best_next;
    logic               overflow_reg, overflow_next;
    logic               exceeded_reg, exceeded_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic               last_reg, last_next;
    logic [SUM_W-1:0]   key_reg, key_next;
    logic               pass_reg, pass_next;
    logic [AW-1:0]      probe_addr_reg, probe_addr_next;
    logic [AW-1:0]      probe_cnt_reg, probe_cnt_next;
    logic [LEN_W-1:0]   out_best_reg, out_best_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_long_reg, out_long_next;

    // map memory ports
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    lsts_pkg::map_entry_t ram_wr_data;
    logic                 ram_rd_en;
    lsts_pkg::map_entry_t ram_rd_data;

    // probe and compare helpers
    logic [SUM_W-1:0] elem_ext;
    logic             entry_live;
    logic             entry_hit;
    logic             probe_last;
    logic [LEN_W-1:0] cand_sum;
    logic [LEN_W-1:0] cand_gap;
    logic             out_free;
    logic [AW-1:0]    probe_addr_inc;

    assign elem_ext       = SUM_W'(element_value);
    assign entry_live     = (ram_rd_data.epoch == epoch_reg);
    assign entry_hit      = entry_live && (ram_rd_data.key == key_reg);
    assign probe_last     = (probe_cnt_reg == LAST_ADDR);
    assign cand_sum       = count_reg + LEN_W'(1);
    assign cand_gap       = count_reg - LEN_W'(ram_rd_data.first);
    assign out_free       = !out_valid_reg || !out_stall;
    assign probe_addr_inc = (probe_addr_reg == LAST_ADDR) ? '0 : probe_addr_reg + AW'(1);

    lsts_map_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (probe_addr_reg),
        .rd_data (ram_rd_data)
    );

    // map memory access
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = probe_addr_reg;
        ram_wr_data = '{key: key_reg, first: IDX_W'(count_reg), epoch: epoch_reg};
        ram_rd_en   = (state_reg == S_RD);
        if (state_reg == S_CLR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '{key: '0, first: '0, epoch: '0};
        end
        else if (state_reg == S_CMP && pass_reg == PASS_SUM && !entry_hit && !entry_live)
        begin
            ram_wr_en = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        best_next       = best_reg;
        overflow_next   = overflow_reg;
        exceeded_next   = exceeded_reg;
        clr_addr_next   = clr_addr_reg;
        epoch_next      = epoch_reg;
        out_valid_next  = out_valid_reg && out_stall;
        last_next       = last_reg;
        key_next        = key_reg;
        pass_next       = pass_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        out_best_next   = out_best_reg;
        out_ovf_next    = out_ovf_reg;
        out_long_next   = out_long_reg;

        if (cfg_wr_en)
        begin
            target_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_CLR:
            begin
                clr_addr_next = probe_addr_inc_clr(clr_addr_reg);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = last_element;
                    if (count_reg >= MAX_LEN_V)
                    begin
                        exceeded_next = 1'b1;
                        if (last_element)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        sum_next   = sum_reg + elem_ext;
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                // whole prefix matches, then look up sum minus target
                if (sum_reg == target_reg && cand_sum > best_reg)
                begin
                    best_next = cand_sum;
                end
                key_next   = sum_reg - target_reg;
                pass_next  = PASS_DIFF;
                state_next = S_HASH;
            end
            S_HASH:
            begin
                probe_addr_next = hash_index(key_reg);
                probe_cnt_next  = '0;
                state_next      = S_RD;
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (pass_reg == PASS_DIFF)
                begin
                    if (entry_hit || !entry_live || probe_last)
                    begin
                        if (entry_hit && cand_gap > best_reg)
                        begin
                            best_next = cand_gap;
                        end
                        key_next   = sum_reg;
                        pass_next  = PASS_SUM;
                        state_next = S_HASH;
                    end
                    else
                    begin
                        probe_addr_next = probe_addr_inc;
                        probe_cnt_next  = probe_cnt_reg + AW'(1);
                        state_next      = S_RD;
                    end
                end
                else
                begin
                    if (entry_hit || !entry_live || probe_last)
                    begin
                        // new sum goes into the free slot; none left means overflow
                        if (!entry_hit && entry_live)
                        begin
                            overflow_next = 1'b1;
                        end
                        count_next = count_reg + LEN_W'(1);
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        probe_addr_next = probe_addr_inc;
                        probe_cnt_next  = probe_cnt_reg + AW'(1);
                        state_next      = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                // emit the result item and start a fresh sequence
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = best_reg;
                    out_ovf_next   = overflow_reg;
                    out_long_next  = exceeded_reg;
                    sum_next       = '0;
                    count_next     = '0;
                    best_next      = '0;
                    overflow_next  = 1'b0;
                    exceeded_next  = 1'b0;
                    if (epoch_reg == EPOCH_MAX)
                    begin
                        epoch_next    = EPOCH_ONE;
                        clr_addr_next = '0;
                        state_next    = S_CLR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + EPOCH_ONE;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            target_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            best_reg      <= '0;
            overflow_reg  <= 1'b0;
            exceeded_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            epoch_reg     <= EPOCH_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
            overflow_reg  <= overflow_next;
            exceeded_reg  <= exceeded_next;
            clr_addr_reg  <= clr_addr_next;
            epoch_reg     <= epoch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        key_reg        <= key_next;
        pass_reg       <= pass_next;
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg  <= probe_cnt_next;
        out_best_reg   <= out_best_next;
        out_ovf_reg    <= out_ovf_next;
        out_long_reg   <= out_long_next;
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign best_length       = out_best_reg;
    assign map_overflow      = out_ovf_reg;
    assign sequence_too_long = out_long_reg;

endmodule

// ===== sim/longest_subarray_target_sum_unit_tb.sv =====
// longest_subarray_target_sum_unit_tb: self-checking bench for the longest
// target-sum run block, with a prefix-map predictor in a scoreboard class
// depends on lsts_pkg and longest_subarray_target_sum_unit
module longest_subarray_target_sum_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W         = lsts_pkg::SUM_W;
    localparam int LEN_W         = lsts_pkg::LEN_W;
    localparam int MAP_DEPTH     = 1024;
    localparam int MAX_LEN       = 65536;
    localparam int ELEM_W        = 16;
    localparam int RESET_CYCLES  = 11;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 85;
    localparam int PHASE_COUNT   = 8;

    // one expected result item
    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             overflow;
        logic             too_long;
    } run_report_t;

    // prefix-sum map predictor and queue of expected run reports
    class target_run_tracker;
        bit [SUM_W-1:0] target;
        bit [SUM_W-1:0] running;
        int unsigned    taken;
        bit [LEN_W-1:0] longest;
        int unsigned    first_index[bit [SUM_W-1:0]];
        bit             dropped_sum;
        bit             overlong;
        run_report_t    pending_reports[$];
        int unsigned    failures;
        int unsigned    elements_noted;
        int unsigned    results_checked;

        // fold one accepted element into the run search
        function void note_element(bit [ELEM_W-1:0] value, bit last);
            bit [SUM_W-1:0] gap_key;
            bit [LEN_W-1:0] span;
            run_report_t    report;
            elements_noted++;
            if (taken >= MAX_LEN)
            begin
                overlong = 1'b1;
            end
            else
            begin
                running = running + {{(SUM_W-ELEM_W){value[ELEM_W-1]}}, value};
                // whole prefix hits the target
                if (running == target)
                begin
                    span = LEN_W'(taken + 1);
                    if (span > longest)
                        longest = span;
                end
                // run ending here that starts after an earlier prefix
                gap_key = running - target;
                if (first_index.exists(gap_key))
                begin
                    span = LEN_W'(taken - first_index[gap_key]);
                    if (span > longest)
                        longest = span;
                end
                // keep only the first index of each sum, drop when full
                if (!first_index.exists(running))
                begin
                    if (first_index.num() < MAP_DEPTH)
                        first_index[running] = taken;
                    else
                        dropped_sum = 1'b1;
                end
                taken++;
            end
            if (last)
            begin
                report.length   = longest;
                report.overflow = dropped_sum;
                report.too_long = overlong;
                pending_reports.push_back(report);
                running     = '0;
                taken       = 0;
                longest     = '0;
                dropped_sum = 1'b0;
                overlong    = 1'b0;
                first_index.delete();
            end
        endfunction

        // compare one accepted result item with the oldest expectation
        function void check_result(logic [LEN_W-1:0] length, logic overflow,
                                   logic too_long);
            run_report_t report;
            if (pending_reports.size() == 0)
            begin
                $error("result item with none expected: best_length %0d", length);
                failures++;
                return;
            end
            report = pending_reports.pop_front();
            results_checked++;
            if (length !== report.length)
            begin
                $error("best_length: expected %0d, got %0d", report.length, length);
                failures++;
            end
            if (overflow !== report.overflow)
            begin
                $error("map_overflow: expected %0b, got %0b", report.overflow, overflow);
                failures++;
            end
            if (too_long !== report.too_long)
            begin
                $error("sequence_too_long: expected %0b, got %0b",
                       report.too_long, too_long);
                failures++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic signed [SUM_W-1:0]  cfg_wr_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_element;
    logic                     out_valid;
    logic                     out_stall;
    logic [LEN_W-1:0]         best_length;
    logic                     map_overflow;
    logic                     sequence_too_long;

    target_run_tracker tracker = new();
    bit                sender_idles      = 1'b1;
    bit                receiver_idles    = 1'b1;
    bit                long_hold_pending = 1'b0;
    int unsigned       target_writes     = 0;

    longest_subarray_target_sum_unit #(
        .TABLE_DEPTH   (MAP_DEPTH),
        .MAX_LENGTH    (MAX_LEN),
        .ELEMENT_WIDTH (ELEM_W)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .element_value     (element_value),
        .last_element      (last_element),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .best_length       (best_length),
        .map_overflow      (map_overflow),
        .sequence_too_long (sequence_too_long)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // offer one element and hold it until taken
    task automatic send_element(input logic signed [ELEM_W-1:0] value, input logic last);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        element_value <= value;
        last_element  <= last;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_element(value, last);
    endtask

    // one sequence, mark on the final element
    task automatic send_sequence(input logic signed [ELEM_W-1:0] values[$]);
        foreach (values[k])
            send_element(values[k], k == values.size() - 1);
    endtask

    // stop offering and wait until every expected result item is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // target register write, block idle
    task automatic write_target(input logic signed [SUM_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.target = value;
        target_writes++;
    endtask

    // result side: random stall bursts, one long hold on request
    initial
    begin : result_side
        int unsigned stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_result(best_length, map_overflow, sequence_too_long);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (receiver_idles && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL longest_subarray_target_sum_unit");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        logic signed [ELEM_W-1:0] seq[$];
        logic signed [ELEM_W-1:0] elem;
        logic signed [SUM_W-1:0]  phase_target[PHASE_COUNT];
        int unsigned              phase;
        int unsigned              phase_items;
        int unsigned              seq_len;
        int unsigned              pick;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_valid      <= 1'b0;
        element_value <= '0;
        last_element  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes and cancelling runs at the reset target of zero
        seq = '{0};
        send_sequence(seq);
        seq = '{16'sh7fff, 16'sh8000, 1};
        send_sequence(seq);
        seq = '{16'sh8000};
        send_sequence(seq);
        seq = '{5, -5, 7, -7, 3};
        send_sequence(seq);

        // small positive target, run found through a stored prefix
        drain_results();
        write_target(32'sd5);
        seq = '{2, 3, -1, 1, 5};
        send_sequence(seq);

        // difference of sum and target wraps at both extreme targets
        drain_results();
        write_target(32'sh7fff_ffff);
        seq = '{-1, 16'sh7fff, 0};
        send_sequence(seq);
        drain_results();
        write_target(32'sh8000_0000);
        seq = '{1, -1, 16'sh8000};
        send_sequence(seq);

        // negative target
        drain_results();
        write_target(-32'sd3);
        seq = '{-1, -1, -1, 0};
        send_sequence(seq);

        // map full: strictly rising sums overrun the table
        drain_results();
        write_target(32'sd6);
        seq.delete();
        repeat (MAP_DEPTH + 6)
        begin
            elem = ELEM_W'($urandom_range(1, 3));
            seq.push_back(elem);
        end
        send_sequence(seq);

        // random sequences over several target settings
        phase_target = '{32'sd3, -32'sd2, 32'sd0, 32'sd1, 32'sd0, 32'sd0, -32'sd1, 32'sd6};
        phase_target[4] = $urandom_range(0, 80) - 40;
        phase_target[5] = $urandom;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            write_target(phase_target[phase]);
            // receiver holds off while the sender keeps offering
            if (phase == 1)
                long_hold_pending = 1'b1;
            // closing stretch runs without idling
            if (phase == PHASE_COUNT - 1)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                seq.delete();
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    seq_len = $urandom_range(1, 12);
                else if (pick < 97)
                    seq_len = $urandom_range(13, 60);
                else
                    seq_len = $urandom_range(61, 300);
                repeat (seq_len)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        elem = ELEM_W'(int'($urandom_range(0, 8)) - 4);
                    else if (pick < 9)
                        elem = ELEM_W'($urandom);
                    else
                    begin
                        case ($urandom_range(0, 3))
                            0:       elem = 16'sh7fff;
                            1:       elem = 16'sh8000;
                            2:       elem = 0;
                            default: elem = -1;
                        endcase
                    end
                    seq.push_back(elem);
                end
                send_sequence(seq);
                phase_items += seq_len;
            end
        end

        drain_results();
        $display("run summary: %0d elements, %0d result items, %0d target writes",
                 tracker.elements_noted, tracker.results_checked, target_writes);
        $display("covered full map, wrapped differences, random targets and stalls");
        if (tracker.failures == 0)
            $display("PASS longest_subarray_target_sum_unit");
        else
            $display("FAIL longest_subarray_target_sum_unit");
        $finish;
    end

endmodule
